// ===== rtl/phong_light_shading_top_defines.svh =====
// Assertion macros for the phong light shading block
`ifndef PHONG_LIGHT_SHADING_TOP_DEFINES_SVH
`define PHONG_LIGHT_SHADING_TOP_DEFINES_SVH
`ifndef SYNTH
`define PHLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PHLS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PHLS_ASSERT(lbl, prop, msg)
`define PHLS_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ===== rtl/phls_pkg.sv =====
// Shared constants and types for the phong light shading block
`timescale 1ns / 1ps
package phls_pkg;
  localparam int LANES      = 3;
  localparam int KS_W       = 16;
  localparam int SHINE_W    = 8;
  localparam int POW_STAGES = 255;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam logic [KS_W-1:0]    KS_RESET    = 16'd9830;
  localparam logic [SHINE_W-1:0] SHINE_RESET = 8'd250;

  typedef enum logic {
    REG_SPEC_GAIN = 1'b0,
    REG_SHININESS = 1'b1
  } reg_idx_t;
endpackage

// ===== rtl/phls_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband
`timescale 1ns / 1ps
module phls_isqrt #(
  parameter int RW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [2*RW-1:0]   in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);
  import phls_pkg::*;

  localparam int XW = 2*RW + 1;

  logic [XW-1:0]     rem_r  [RW];
  logic [XW-1:0]     root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [RW-1:0]     vld_r;

  for (genvar k = 0; k < RW; k++) begin : g_stg
    localparam logic [XW-1:0] BIT = XW'(1) << (2*(RW-1-k));
    logic [XW-1:0]     rem_i;
    logic [XW-1:0]     root_i;
    logic [XW-1:0]     trial;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i;

    if (k == 0) begin : g_first
      assign rem_i  = {1'b0, in_x};
      assign root_i = '0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign trial = root_i + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k]  <= rem_i - trial;
          root_r[k] <= (root_i >> 1) + BIT;
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i >> 1;
        end
        side_r[k] <= side_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1][RW-1:0];
  assign out_side = side_r[RW-1];
endmodule

// ===== rtl/phls_div.sv =====
// Pipelined restoring divider for the normalized view vector, three lanes
`timescale 1ns / 1ps
module phls_div #(
  parameter int VW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [VW-1:0] in_d [phls_pkg::LANES],
  input  logic [VW-1:0]        in_len,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic signed [VW-1:0] out_v [phls_pkg::LANES],
  output logic [SIDE_W-1:0]    out_side
);
  import phls_pkg::*;

  localparam int F  = VW - 2;
  localparam int Q  = F + 1;
  localparam int NW = 2*VW - 2;

  logic [NW-1:0]     rem_r  [Q][LANES];
  logic [Q-1:0]      q_r    [Q][LANES];
  logic              pos_r  [Q][LANES];
  logic [VW-1:0]     len_r  [Q];
  logic              zero_r [Q];
  logic [SIDE_W-1:0] side_r [Q];
  logic [Q-1:0]      vld_r;

  for (genvar j = 0; j < Q; j++) begin : g_stg
    localparam int K = Q - 1 - j;
    logic [NW-1:0]     rem_i [LANES];
    logic [Q-1:0]      q_i   [LANES];
    logic              pos_i [LANES];
    logic [NW-1:0]     trial;
    logic [VW-1:0]     len_i;
    logic              zero_i;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i;

    if (j == 0) begin : g_first
      logic [VW-1:0] mag [LANES];

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          mag[l]   = in_d[l][VW-1] ? VW'(-in_d[l]) : VW'(in_d[l]);
          rem_i[l] = {mag[l], {F{1'b0}}};
          q_i[l]   = '0;
          pos_i[l] = !in_d[l][VW-1] && (in_d[l] != '0);
        end
      end
      assign len_i  = in_len;
      assign zero_i = (in_len == '0);
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign q_i    = q_r[j-1];
      assign pos_i  = pos_r[j-1];
      assign len_i  = len_r[j-1];
      assign zero_i = zero_r[j-1];
      assign side_i = side_r[j-1];
      assign vld_i  = vld_r[j-1];
    end

    assign trial = NW'(len_i) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (rem_i[l] >= trial) begin
            rem_r[j][l] <= rem_i[l] - trial;
            q_r[j][l]   <= q_i[l] | (Q'(1) << K);
          end else begin
            rem_r[j][l] <= rem_i[l];
            q_r[j][l]   <= q_i[l];
          end
          pos_r[j][l] <= pos_i[l];
        end
        len_r[j]  <= len_i;
        zero_r[j] <= zero_i;
        side_r[j] <= side_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end
  end

  logic signed [VW-1:0] qx [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qx[l] = VW'(q_r[Q-1][l]);
      if (zero_r[Q-1]) begin
        out_v[l] = '0;
      end else if (pos_r[Q-1][l]) begin
        out_v[l] = -qx[l];
      end else begin
        out_v[l] = qx[l];
      end
    end
  end

  assign out_vld  = vld_r[Q-1];
  assign out_side = side_r[Q-1];
endmodule

// ===== rtl/phong_light_shading_top.sv =====
// Phong diffuse and specular shading pipeline, top level
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; a stall on the output freezes the whole pipeline.
// Depth is set by the shininess power chain (255 multiply stages), the bit-per-stage
// square root (VEC_WIDTH stages) and divider (VEC_WIDTH-1 stages).
// Reset: synchronous active low; clears valid bits and restores ks and shininess.
`include "phong_light_shading_top_defines.svh"
module phong_light_shading_top #(
  parameter int VEC_WIDTH   = 16,
  parameter int COLOR_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VEC_WIDTH-1:0]    in_light_dir_x,
  input  logic signed [VEC_WIDTH-1:0]    in_light_dir_y,
  input  logic signed [VEC_WIDTH-1:0]    in_light_dir_z,
  input  logic signed [VEC_WIDTH-1:0]    in_normal_x,
  input  logic signed [VEC_WIDTH-1:0]    in_normal_y,
  input  logic signed [VEC_WIDTH-1:0]    in_normal_z,
  input  logic signed [VEC_WIDTH-1:0]    in_view_ray_x,
  input  logic signed [VEC_WIDTH-1:0]    in_view_ray_y,
  input  logic signed [VEC_WIDTH-1:0]    in_view_ray_z,
  input  logic [COLOR_WIDTH-1:0]         in_light_red,
  input  logic [COLOR_WIDTH-1:0]         in_light_green,
  input  logic [COLOR_WIDTH-1:0]         in_light_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COLOR_WIDTH-1:0]         out_diffuse_red,
  output logic [COLOR_WIDTH-1:0]         out_diffuse_green,
  output logic [COLOR_WIDTH-1:0]         out_diffuse_blue,
  output logic [COLOR_WIDTH-1:0]         out_specular_red,
  output logic [COLOR_WIDTH-1:0]         out_specular_green,
  output logic [COLOR_WIDTH-1:0]         out_specular_blue,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [phls_pkg::APB_AW-1:0]    paddr,
  input  logic [phls_pkg::APB_DW-1:0]    pwdata,
  output logic [phls_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import phls_pkg::*;

  localparam int W     = VEC_WIDTH;
  localparam int C     = COLOR_WIDTH;
  localparam int F     = W - 2;
  localparam int PW    = 2*W;
  localparam int DSW   = W + 4;
  localparam int CW    = C + W;
  localparam int SA_W  = 6*W + 6*C;
  localparam int SB_W  = 3*W + 6*C;
  localparam logic [W-1:0] ONE = W'(1) << F;

  // configuration registers
  logic [KS_W-1:0]    ks_r;
  logic [SHINE_W-1:0] shine_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r    <= KS_RESET;
      shine_r <= SHINE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPEC_GAIN: ks_r    <= pwdata[KS_W-1:0];
        REG_SHININESS: shine_r <= pwdata[SHINE_W-1:0];
        default:       ks_r    <= ks_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEC_GAIN: prdata = APB_DW'(ks_r);
      REG_SHININESS: prdata = APB_DW'(shine_r);
      default:       prdata = '0;
    endcase
  end

  // pipeline advance
  logic adv;
  logic out_vld_r;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  logic signed [W-1:0] l_in   [LANES];
  logic signed [W-1:0] n_in   [LANES];
  logic signed [W-1:0] d_in   [LANES];
  logic [C-1:0]        col_in [LANES];

  assign l_in   = '{in_light_dir_x, in_light_dir_y, in_light_dir_z};
  assign n_in   = '{in_normal_x, in_normal_y, in_normal_z};
  assign d_in   = '{in_view_ray_x, in_view_ray_y, in_view_ray_z};
  assign col_in = '{in_light_red, in_light_green, in_light_blue};

  // stage 1: dot products, squares, color * ks
  logic signed [PW-1:0]  nl1_r  [LANES];
  logic signed [PW-1:0]  dd1_r  [LANES];
  logic [C-1:0]          cks1_r [LANES];
  logic signed [W-1:0]   l1_r   [LANES];
  logic signed [W-1:0]   n1_r   [LANES];
  logic signed [W-1:0]   d1_r   [LANES];
  logic [C-1:0]          col1_r [LANES];
  logic                  v1_r;
  logic [C+KS_W-1:0]     ckp    [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ckp[i] = (C+KS_W)'(col_in[i]) * (C+KS_W)'(ks_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        nl1_r[i]  <= PW'(n_in[i]) * PW'(l_in[i]);
        dd1_r[i]  <= PW'(d_in[i]) * PW'(d_in[i]);
        cks1_r[i] <= ckp[i][C+KS_W-1:KS_W];
        l1_r[i]   <= l_in[i];
        n1_r[i]   <= n_in[i];
        d1_r[i]   <= d_in[i];
        col1_r[i] <= col_in[i];
      end
    end
  end

  // stage 2: N.L sum and clamps, |D|^2
  logic signed [DSW-1:0] dot;
  logic [W-1:0]          kd;
  logic signed [W-1:0]   ds;
  logic [PW-1:0]         sq;
  logic [W-1:0]          kd2_r;
  logic signed [W-1:0]   ds2_r;
  logic [PW-1:0]         sq2_r;
  logic signed [W-1:0]   l2_r   [LANES];
  logic signed [W-1:0]   n2_r   [LANES];
  logic signed [W-1:0]   d2_r   [LANES];
  logic [C-1:0]          col2_r [LANES];
  logic [C-1:0]          cks2_r [LANES];
  logic                  v2_r;

  always_comb begin
    dot = '0;
    sq  = '0;
    for (int i = 0; i < LANES; i++) begin
      dot = dot + DSW'(nl1_r[i] >>> F);
      sq  = sq + $unsigned(dd1_r[i]);
    end
    if (dot[DSW-1]) begin
      kd = '0;
    end else if (|dot[DSW-2:W]) begin
      kd = '1;
    end else begin
      kd = dot[W-1:0];
    end
    if (dot[DSW-1:W-1] == '0 || dot[DSW-1:W-1] == '1) begin
      ds = dot[W-1:0];
    end else if (dot[DSW-1]) begin
      ds = {1'b1, {(W-1){1'b0}}};
    end else begin
      ds = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kd2_r  <= kd;
      ds2_r  <= ds;
      sq2_r  <= sq;
      l2_r   <= l1_r;
      n2_r   <= n1_r;
      d2_r   <= d1_r;
      col2_r <= col1_r;
      cks2_r <= cks1_r;
    end
  end

  // stage 3: ds * N and color * kd
  logic signed [PW-1:0] dn3_r  [LANES];
  logic [CW-1:0]        ckd3_r [LANES];
  logic signed [W-1:0]  l3_r   [LANES];
  logic signed [W-1:0]  d3_r   [LANES];
  logic [C-1:0]         cks3_r [LANES];
  logic [PW-1:0]        sq3_r;
  logic                 v3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        dn3_r[i]  <= PW'(ds2_r) * PW'(n2_r[i]);
        ckd3_r[i] <= CW'(col2_r[i]) * CW'(kd2_r);
      end
      l3_r   <= l2_r;
      d3_r   <= d2_r;
      cks3_r <= cks2_r;
      sq3_r  <= sq2_r;
    end
  end

  // stage 4: reflection vector, diffuse color
  logic signed [DSW-1:0] rt   [LANES];
  logic signed [W-1:0]   rr   [LANES];
  logic [C-1:0]          dfc  [LANES];
  logic signed [W-1:0]   r4_r    [LANES];
  logic [C-1:0]          diff4_r [LANES];
  logic signed [W-1:0]   d4_r    [LANES];
  logic [C-1:0]          cks4_r  [LANES];
  logic [PW-1:0]         sq4_r;
  logic                  v4_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rt[i] = DSW'(dn3_r[i] >>> (F-1)) - DSW'(l3_r[i]);
      if (rt[i][DSW-1:W-1] == '0 || rt[i][DSW-1:W-1] == '1) begin
        rr[i] = rt[i][W-1:0];
      end else if (rt[i][DSW-1]) begin
        rr[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        rr[i] = {1'b0, {(W-1){1'b1}}};
      end
      dfc[i] = (|ckd3_r[i][CW-1:CW-2]) ? '1 : ckd3_r[i][F+C-1:F];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_r    <= rr;
      diff4_r <= dfc;
      d4_r    <= d3_r;
      cks4_r  <= cks3_r;
      sq4_r   <= sq3_r;
    end
  end

  // square root of |D|^2
  logic [SA_W-1:0]     side_a_in;
  logic [SA_W-1:0]     side_a;
  logic [W-1:0]        len_a;
  logic                vld_a;
  logic signed [W-1:0] d_a [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      side_a_in[i*W +: W]             = r4_r[i];
      side_a_in[3*W + i*W +: W]       = d4_r[i];
      side_a_in[6*W + i*C +: C]       = cks4_r[i];
      side_a_in[6*W + 3*C + i*C +: C] = diff4_r[i];
    end
  end

  phls_isqrt #(
    .RW     (W),
    .SIDE_W (SA_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v4_r),
    .in_x     (sq4_r),
    .in_side  (side_a_in),
    .out_vld  (vld_a),
    .out_root (len_a),
    .out_side (side_a)
  );

  // V = -D / |D|
  logic [SB_W-1:0]     side_b_in;
  logic [SB_W-1:0]     side_c;
  logic                vld_c;
  logic signed [W-1:0] v_c [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      d_a[i]                          = side_a[3*W + i*W +: W];
      side_b_in[i*W +: W]             = side_a[i*W +: W];
      side_b_in[3*W + i*C +: C]       = side_a[6*W + i*C +: C];
      side_b_in[3*W + 3*C + i*C +: C] = side_a[6*W + 3*C + i*C +: C];
    end
  end

  phls_div #(
    .VW     (W),
    .SIDE_W (SB_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (vld_a),
    .in_d     (d_a),
    .in_len   (len_a),
    .in_side  (side_b_in),
    .out_vld  (vld_c),
    .out_v    (v_c),
    .out_side (side_c)
  );

  // stage 5: R * V products
  logic signed [PW-1:0] rv5_r   [LANES];
  logic [C-1:0]         cks5_r  [LANES];
  logic [C-1:0]         diff5_r [LANES];
  logic                 v5_r;
  logic signed [W-1:0]  r_c     [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      r_c[i] = side_c[i*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        rv5_r[i]   <= PW'(r_c[i]) * PW'(v_c[i]);
        cks5_r[i]  <= side_c[3*W + i*C +: C];
        diff5_r[i] <= side_c[3*W + 3*C + i*C +: C];
      end
    end
  end

  // stage 6: R.V sum and clamp
  logic signed [DSW-1:0] rvs;
  logic [W-1:0]          sc;
  logic [W-1:0]          s6_r;
  logic [C-1:0]          cks6_r  [LANES];
  logic [C-1:0]          diff6_r [LANES];
  logic                  v6_r;

  always_comb begin
    rvs = '0;
    for (int i = 0; i < LANES; i++) begin
      rvs = rvs + DSW'(rv5_r[i] >>> F);
    end
    if (rvs[DSW-1]) begin
      sc = '0;
    end else if (|rvs[DSW-2:W]) begin
      sc = '1;
    end else begin
      sc = rvs[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r    <= sc;
      cks6_r  <= cks5_r;
      diff6_r <= diff5_r;
    end
  end

  // power chain: one saturating multiply per shininess step
  logic [W-1:0]          pw_p_r    [POW_STAGES];
  logic [W-1:0]          pw_s_r    [POW_STAGES];
  logic [C-1:0]          pw_cks_r  [POW_STAGES][LANES];
  logic [C-1:0]          pw_diff_r [POW_STAGES][LANES];
  logic [POW_STAGES-1:0] pw_v_r;

  for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
    logic [W-1:0]  p_i;
    logic [W-1:0]  s_i;
    logic [C-1:0]  cks_i  [LANES];
    logic [C-1:0]  diff_i [LANES];
    logic          vld_i;
    logic [PW-1:0] prod;
    logic [W-1:0]  p_o;

    if (k == 0) begin : g_first
      assign p_i    = ONE;
      assign s_i    = s6_r;
      assign cks_i  = cks6_r;
      assign diff_i = diff6_r;
      assign vld_i  = v6_r;
    end else begin : g_next
      assign p_i    = pw_p_r[k-1];
      assign s_i    = pw_s_r[k-1];
      assign cks_i  = pw_cks_r[k-1];
      assign diff_i = pw_diff_r[k-1];
      assign vld_i  = pw_v_r[k-1];
    end

    assign prod = PW'(p_i) * PW'(s_i);

    always_comb begin
      if (SHINE_W'(k) < shine_r) begin
        p_o = (|prod[PW-1:PW-2]) ? '1 : prod[F+W-1:F];
      end else begin
        p_o = p_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pw_p_r[k]    <= p_o;
        pw_s_r[k]    <= s_i;
        pw_cks_r[k]  <= cks_i;
        pw_diff_r[k] <= diff_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_v_r[k] <= 1'b0;
      end else if (adv) begin
        pw_v_r[k] <= vld_i;
      end
    end
  end

  // stage 7: specular product
  logic [CW-1:0] sp7_r   [LANES];
  logic [C-1:0]  diff7_r [LANES];
  logic          v7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        sp7_r[i] <= CW'(pw_cks_r[POW_STAGES-1][i]) * CW'(pw_p_r[POW_STAGES-1]);
      end
      diff7_r <= pw_diff_r[POW_STAGES-1];
    end
  end

  // output register
  logic [C-1:0] out_diff_r [LANES];
  logic [C-1:0] out_spec_r [LANES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        out_spec_r[i] <= (|sp7_r[i][CW-1:CW-2]) ? '1 : sp7_r[i][F+C-1:F];
      end
      out_diff_r <= diff7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      v7_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= vld_c;
      v6_r      <= v5_r;
      v7_r      <= pw_v_r[POW_STAGES-1];
      out_vld_r <= v7_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_diffuse_red    = out_diff_r[0];
  assign out_diffuse_green  = out_diff_r[1];
  assign out_diffuse_blue   = out_diff_r[2];
  assign out_specular_red   = out_spec_r[0];
  assign out_specular_green = out_spec_r[1];
  assign out_specular_blue  = out_spec_r[2];

  `PHLS_ASSERT_ANY(a_rst_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `PHLS_ASSERT(a_shine_write, (cfg_wr && cfg_idx == REG_SHININESS) |=> (shine_r == $past(pwdata[SHINE_W-1:0])), "shininess write lost")
  `PHLS_ASSERT(a_pow_hold, !adv |=> $stable(pw_p_r[0]), "power stage moved while stalled")
  `PHLS_ASSERT(a_stall_back, (out_valid && out_stall) |-> in_stall, "input taken while output blocked")
endmodule
